### sv/fes_pkg.sv
// Shared types and constants for the FIFO-evicting keyed store.
`timescale 1ns / 1ps

package fes_pkg;

    localparam int KEY_W    = 32;
    localparam int HANDLE_W = 32;
    localparam int LIMIT_W  = 7;

    localparam logic [LIMIT_W-1:0] BUFFER_LIMIT_RESET = 7'd64;

    // Action codes of an input item.
    localparam logic ACTION_LOOKUP = 1'b0;
    localparam logic ACTION_ADD    = 1'b1;

    // One input item.
    typedef struct packed {
        logic                       action;
        logic signed [KEY_W-1:0]    key;
        logic        [HANDLE_W-1:0] handle_in;
    } t_item;

    // One result item.
    typedef struct packed {
        logic                hit;
        logic [HANDLE_W-1:0] handle_out;
        logic                duplicate;
        logic                evicted;
    } t_result;

    // One slot of the insertion ring: the queued key, its handle and
    // whether this queued copy currently owns the key's mapping.
    typedef struct packed {
        logic                mapped;
        logic [HANDLE_W-1:0] handle;
        logic [KEY_W-1:0]    key;
    } t_ring_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan;
        logic erase_wr;
        logic push_wr;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
        logic erase_pend;
        logic is_add;
    } t_dp_status;

endpackage

### sv/fes_ctrl.sv
// Controller state machine that sequences scan, erase, push and result.
`timescale 1ns / 1ps

module fes_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  fes_pkg::t_dp_status i_status,
    output fes_pkg::t_dp_cmd    o_cmd,
    output logic                busy,
    output logic                o_done
);
    import fes_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ERASE,
        S_PUSH,
        S_RESULT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_done;

    // Next state and commands for the datapath.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_done) begin
                    if (i_status.erase_pend) begin
                        n_state = S_ERASE;
                    end else if (i_status.is_add) begin
                        n_state = S_PUSH;
                    end else begin
                        n_state = S_RESULT;
                    end
                end
            end
            S_ERASE: begin
                o_cmd.erase_wr = 1'b1;
                n_state        = i_status.is_add ? S_PUSH : S_RESULT;
            end
            S_PUSH: begin
                o_cmd.push_wr = 1'b1;
                n_state       = S_RESULT;
            end
            S_RESULT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and the registered result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (n_state == S_RESULT);
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

### sv/fes_datapath.sv
// Datapath: insertion ring memory, scan comparator, queue pointers and limit.
`timescale 1ns / 1ps

module fes_datapath #(
    parameter int DEPTH = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  fes_pkg::t_dp_cmd               i_cmd,
    output fes_pkg::t_dp_status            o_status,
    input  fes_pkg::t_item                 i_item,
    input  logic                           i_cfg_wr_en,
    input  logic [fes_pkg::LIMIT_W-1:0]    i_cfg_wr_data,
    output fes_pkg::t_result               o_result
);
    import fes_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

    // Ring memory.
    t_ring_word r_mem [DEPTH];
    t_ring_word r_rd_word;

    // Queue state and configuration.
    logic [IW-1:0]      r_head;
    logic [CW-1:0]      r_count;
    logic [LIMIT_W-1:0] r_buffer_limit;

    // Current item.
    logic [KEY_W-1:0]    r_key;
    logic [HANDLE_W-1:0] r_handle;
    logic                r_is_add;
    logic                r_evict;

    // Scan engine.
    logic [IW-1:0] r_rd_ptr;
    logic [IW-1:0] r_rd_addr;
    logic [CW-1:0] r_left;
    logic          r_first_issue;
    logic          r_rd_first;
    logic          r_rd_vld;
    logic [KEY_W-1:0] r_old_key;

    // Scan findings.
    logic                r_found;
    logic [HANDLE_W-1:0] r_found_handle;
    logic                r_erase_pend;
    logic [IW-1:0]       r_erase_idx;
    t_ring_word          r_erase_word;

    logic             rd_en;
    logic             evict_cond;
    logic [KEY_W-1:0] old_key;
    logic             old_match;
    logic             new_match;
    logic [IW-1:0]    head_n;
    logic [CW-1:0]    cnt_p;
    logic [SW-1:0]    tail_sum;
    logic [SW-1:0]    tail_full;
    logic             wr_en;
    logic [IW-1:0]    wr_addr;
    t_ring_word       wr_data;

    function automatic logic [IW-1:0] ptr_inc(input logic [IW-1:0] p);
        logic [IW-1:0] r;
        r = (p == IW'(DEPTH - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

    // Eviction test: a limit of zero behaves as one, above DEPTH as DEPTH.
    assign evict_cond = (r_count != '0) &&
                        ((LW'(r_count) >= LW'(r_buffer_limit)) ||
                         (r_count >= CW'(DEPTH)));

    // Compare of the word from the registered ring read.
    assign old_key   = r_rd_first ? r_rd_word.key : r_old_key;
    assign old_match = r_evict && r_rd_word.mapped && (r_rd_word.key == old_key);
    assign new_match = r_rd_word.mapped && (r_rd_word.key == r_key) &&
                       !(r_evict && (r_rd_word.key == old_key));

    assign rd_en = i_cmd.scan && (r_left != '0);

    // Tail slot after the optional pop.
    assign head_n    = r_evict ? ptr_inc(r_head) : r_head;
    assign cnt_p     = r_count - CW'(r_evict);
    assign tail_sum  = SW'(head_n) + SW'(cnt_p);
    assign tail_full = (tail_sum >= SW'(DEPTH)) ? tail_sum - SW'(DEPTH) : tail_sum;

    // Write port: erase clears a mapping, push appends the new key.
    assign wr_en   = i_cmd.erase_wr || i_cmd.push_wr;
    assign wr_addr = i_cmd.push_wr ? tail_full[IW-1:0] : r_erase_idx;
    always_comb begin
        if (i_cmd.push_wr) begin
            wr_data.mapped = !r_found;
            wr_data.handle = r_handle;
            wr_data.key    = r_key;
        end else begin
            wr_data = r_erase_word;
        end
    end

    // Ring memory with registered read.
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_word <= r_mem[r_rd_ptr];
        end
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    // Control registers: queue pointers, limit and scan sequencing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head         <= '0;
            r_count        <= '0;
            r_buffer_limit <= BUFFER_LIMIT_RESET;
            r_left         <= '0;
            r_rd_vld       <= 1'b0;
            r_first_issue  <= 1'b0;
            r_rd_first     <= 1'b0;
            r_found        <= 1'b0;
            r_erase_pend   <= 1'b0;
            r_is_add       <= 1'b0;
            r_evict        <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_buffer_limit <= i_cfg_wr_data;
            end

            if (i_cmd.load) begin
                r_is_add      <= (i_item.action == ACTION_ADD);
                r_evict       <= (i_item.action == ACTION_ADD) && evict_cond;
                r_left        <= r_count;
                r_first_issue <= 1'b1;
                r_rd_vld      <= 1'b0;
                r_found       <= 1'b0;
                r_erase_pend  <= 1'b0;
            end else begin
                // Issue one read per cycle while entries remain.
                r_rd_vld <= rd_en;
                if (rd_en) begin
                    r_left        <= r_left - 1'b1;
                    r_rd_first    <= r_first_issue;
                    r_first_issue <= 1'b0;
                end
                // Record what the word read last cycle matched.
                if (r_rd_vld) begin
                    if (old_match) begin
                        r_erase_pend <= 1'b1;
                    end
                    if (new_match) begin
                        r_found <= 1'b1;
                    end
                end
            end

            if (i_cmd.push_wr) begin
                r_head  <= head_n;
                r_count <= cnt_p + 1'b1;
            end
        end
    end

    // Payload registers of the scan.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key    <= i_item.key;
            r_handle <= i_item.handle_in;
            r_rd_ptr <= r_head;
        end else if (rd_en) begin
            r_rd_ptr <= ptr_inc(r_rd_ptr);
        end
        if (rd_en) begin
            r_rd_addr <= r_rd_ptr;
        end
        if (r_rd_vld && r_rd_first) begin
            r_old_key <= r_rd_word.key;
        end
        if (r_rd_vld && old_match) begin
            r_erase_idx         <= r_rd_addr;
            r_erase_word.mapped <= 1'b0;
            r_erase_word.handle <= r_rd_word.handle;
            r_erase_word.key    <= r_rd_word.key;
        end
        if (r_rd_vld && new_match) begin
            r_found_handle <= r_rd_word.handle;
        end
    end

    assign o_status.scan_done  = (r_left == '0) && !r_rd_vld;
    assign o_status.erase_pend = r_erase_pend;
    assign o_status.is_add     = r_is_add;

    // Result fields, stable from the end of the scan until the next load.
    assign o_result.hit        = !r_is_add && r_found;
    assign o_result.handle_out = (!r_is_add && r_found) ? r_found_handle : '0;
    assign o_result.duplicate  = r_is_add && r_found;
    assign o_result.evicted    = r_evict;

endmodule

### sv/fifo_evicting_keyed_store.sv
// Top level of the keyed handle store with oldest-first eviction.
//
//  Channel   Ports                         Handshake
//  -------   ---------------------------   ---------------------------------
//  item      start, busy, i_item           taken when start=1 and busy=0
//  result    o_done, o_result              valid for the one cycle o_done=1
//  config    i_cfg_wr_en, i_cfg_wr_data    buffer_limit written when enable=1
//
// An item passes through accept, one ring read per queued key, the registered
// read of the last key and the close of the scan, then the erase (only for an add
// whose popped key is still mapped), the push (adds only) and the result.
// Reset (synchronous, active low) empties the queue and sets buffer_limit to 64.
// The receiver cannot stall: each result shows for one cycle; busy holds till then.
`timescale 1ns / 1ps

module fifo_evicting_keyed_store #(
    parameter int DEPTH = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  fes_pkg::t_item              i_item,
    input  logic                        i_cfg_wr_en,
    input  logic [fes_pkg::LIMIT_W-1:0] i_cfg_wr_data,
    output logic                        o_done,
    output fes_pkg::t_result            o_result
);
    import fes_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // Sequencer.
    fes_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (dp_status),
        .o_cmd    (dp_cmd),
        .busy     (busy),
        .o_done   (o_done)
    );

    // Ring storage and compare.
    fes_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_status      (dp_status),
        .i_item        (i_item),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_result      (o_result)
    );

endmodule

### bench/fifo_evicting_keyed_store_test.sv
// Self-checking testbench for the FIFO-evicting keyed handle store.
`timescale 1ns / 1ps

module fifo_evicting_keyed_store_test;

    import fes_pkg::*;

    localparam int STORE_DEPTH   = 64;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 160;
    localparam int PHASE_COUNT   = 10;

    // Flag values used in the directed table.
    localparam bit ON  = 1'b1;
    localparam bit OFF = 1'b0;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_item                i_item;
    logic                 i_cfg_wr_en;
    logic [LIMIT_W-1:0]   i_cfg_wr_data;
    logic                 o_done;
    t_result              o_result;

    // One line of the directed table: either a limit write or an item.
    typedef struct {
        bit                 is_limit_write;
        logic [LIMIT_W-1:0] limit_value;
        t_item              item;
        bit                 typed;
        t_result            want;
    } t_directed_row;

    t_directed_row      directed_rows[$];

    // Shadow of the store: the insertion order and the key-to-handle map.
    logic [KEY_W-1:0]    fifo_keys[$];
    logic [HANDLE_W-1:0] handle_of[logic [KEY_W-1:0]];
    logic [LIMIT_W-1:0]  model_limit;

    t_result awaited_results[$];
    int      error_count = 0;
    int      idle_pct = 38;

    // Set by the driver for the item it is presenting.
    bit      row_typed = 1'b0;
    t_result row_want = '0;

    fifo_evicting_keyed_store #(
        .DEPTH(STORE_DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_item       (i_item),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .o_done       (o_done),
        .o_result     (o_result)
    );

    // Clock with a 2 ns period.
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Computes the response to one item and updates the shadow store.
    function automatic t_result predict_store_response(input t_item it);
        t_result          r;
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] oldest;
        int               lim;
        r = '0;
        k = it.key;
        if (it.action == ACTION_LOOKUP) begin
            if (handle_of.exists(k)) begin
                r.hit = 1'b1;
                r.handle_out = handle_of[k];
            end
            return r;
        end
        // A limit of zero behaves as one, anything above the depth as the depth.
        lim = model_limit;
        if (lim < 1) lim = 1;
        if (lim > STORE_DEPTH) lim = STORE_DEPTH;
        // Pop the oldest queued key first; its mapping goes even if another
        // copy of it is still queued.
        if (fifo_keys.size() > 0 && fifo_keys.size() >= lim) begin
            oldest = fifo_keys.pop_front();
            if (handle_of.exists(oldest)) handle_of.delete(oldest);
            r.evicted = 1'b1;
        end
        fifo_keys.insert(fifo_keys.size(), k);
        if (handle_of.exists(k)) begin
            r.duplicate = 1'b1;
        end else begin
            handle_of[k] = it.handle_in;
        end
        return r;
    endfunction

    // Accepts items and limit writes, and checks each result as it shows.
    always @(posedge i_clk) begin : monitor
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            model_limit = BUFFER_LIMIT_RESET;
            fifo_keys.delete();
            handle_of.delete();
            awaited_results.delete();
        end else begin
            if (o_done) begin
                got = o_result;
                if (awaited_results.size() == 0) begin
                    $error("result with no item outstanding: %h", got);
                    error_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (got.hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, got.hit);
                        error_count++;
                    end
                    if (got.handle_out !== want.handle_out) begin
                        $error("handle_out: expected %h, got %h",
                               want.handle_out, got.handle_out);
                        error_count++;
                    end
                    if (got.duplicate !== want.duplicate) begin
                        $error("duplicate: expected %0d, got %0d",
                               want.duplicate, got.duplicate);
                        error_count++;
                    end
                    if (got.evicted !== want.evicted) begin
                        $error("evicted: expected %0d, got %0d",
                               want.evicted, got.evicted);
                        error_count++;
                    end
                end
            end
            if (i_cfg_wr_en) model_limit = i_cfg_wr_data;
            if (start && !busy) begin
                want = predict_store_response(i_item);
                if (row_typed) want = row_want;
                awaited_results.insert(awaited_results.size(), want);
            end
        end
    end

    // Presents one item, dropping start at random until it is taken.
    task automatic present_item(input t_item it, input bit typed, input t_result want);
        bit          go;
        logic [95:0] noise;
        row_typed = typed;
        row_want  = want;
        forever begin
            go = ($urandom_range(99) >= idle_pct);
            noise = {$urandom, $urandom, $urandom};
            start  <= go;
            i_item <= go ? it : t_item'(noise[$bits(t_item)-1:0]);
            @(posedge i_clk);
            if (go && !busy) break;
            @(negedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // Waits until every result has come back and the block is quiet.
    task automatic settle();
        start <= 1'b0;
        while (awaited_results.size() != 0 || busy) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        settle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic row_item(input logic act, input logic [KEY_W-1:0] key,
                            input logic [HANDLE_W-1:0] handle, input bit typed,
                            input logic hit, input logic [HANDLE_W-1:0] hout,
                            input logic dup, input logic ev);
        t_directed_row row;
        row.is_limit_write = 1'b0;
        row.limit_value    = '0;
        row.item           = '{action: act, key: key, handle_in: handle};
        row.typed          = typed;
        row.want           = '{hit: hit, handle_out: hout, duplicate: dup, evicted: ev};
        directed_rows.insert(directed_rows.size(), row);
    endtask

    task automatic row_limit(input logic [LIMIT_W-1:0] value);
        t_directed_row row;
        row.is_limit_write = 1'b1;
        row.limit_value    = value;
        row.item           = '0;
        row.typed          = 1'b0;
        row.want           = '0;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    // Random items over a small key pool, so that lookups hit and adds collide.
    task automatic run_random_phase(input logic [LIMIT_W-1:0] limit, input int idle);
        logic [KEY_W-1:0] pool[$];
        int               pool_size;
        t_item            it;
        t_result          none;
        none = '0;
        write_limit(limit);
        idle_pct = idle;
        pool_size = $urandom_range(2, 40);
        for (int i = 0; i < pool_size; i++) pool.insert(pool.size(), $urandom);
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            it.action    = ($urandom_range(1) == 1) ? ACTION_ADD : ACTION_LOOKUP;
            it.key       = ($urandom_range(99) < 85) ? pool[$urandom_range(pool_size - 1)]
                                                      : $urandom;
            it.handle_in = $urandom;
            present_item(it, 1'b0, none);
        end
    endtask

    // Stimulus: reset, the directed table, then random phases at many limits.
    initial begin : stimulus
        logic [LIMIT_W-1:0] phase_limits[PHASE_COUNT];
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_item        = '0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        phase_limits  = '{7'd1, 7'd0, 7'd5, 7'd127, 7'd17, 7'd64, 7'd2, 7'd40, 7'd65, 7'd3};

        // Empty store, extreme keys and handles, and a duplicate add.
        row_item(ACTION_LOOKUP, 32'h0000_0000, 32'h0000_0000, ON, OFF, 32'h0, OFF, OFF);
        row_item(ACTION_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000, ON, OFF, 32'h0, OFF, OFF);
        row_item(ACTION_LOOKUP, 32'h8000_0000, 32'hFFFF_FFFF, ON, OFF, 32'h0, OFF, OFF);
        row_item(ACTION_ADD,    32'h8000_0000, 32'hFFFF_FFFF, ON, OFF, 32'h0, OFF, OFF);
        row_item(ACTION_LOOKUP, 32'h8000_0000, 32'h0000_0000, ON, ON, 32'hFFFF_FFFF, OFF, OFF);
        row_item(ACTION_ADD,    32'h7FFF_FFFF, 32'h0000_0000, ON, OFF, 32'h0, OFF, OFF);
        row_item(ACTION_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000, ON, ON, 32'h0, OFF, OFF);
        row_item(ACTION_ADD,    32'h8000_0000, 32'h1234_5678, ON, OFF, 32'h0, ON, OFF);
        row_item(ACTION_LOOKUP, 32'h8000_0000, 32'h0000_0000, ON, ON, 32'hFFFF_FFFF, OFF, OFF);
        row_item(ACTION_ADD,    32'hFFFF_FFFF, 32'hAAAA_AAAA, ON, OFF, 32'h0, OFF, OFF);
        row_item(ACTION_ADD,    32'h0000_0000, 32'h5555_5555, ON, OFF, 32'h0, OFF, OFF);
        row_item(ACTION_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, ON, ON, 32'hAAAA_AAAA, OFF, OFF);
        row_item(ACTION_LOOKUP, 32'h0000_0001, 32'hFFFF_FFFF, ON, OFF, 32'h0, OFF, OFF);
        // A zero limit acts as one, below the queue length: every add pops one.
        row_limit(7'd0);
        row_item(ACTION_ADD,    32'h0000_0001, 32'h0000_0001, ON, OFF, 32'h0, OFF, ON);
        // The popped key is erased although a later copy is still queued.
        row_item(ACTION_LOOKUP, 32'h8000_0000, 32'h0000_0000, ON, OFF, 32'h0, OFF, OFF);
        // The popped key equals the new key: it is stored anew, no duplicate.
        row_item(ACTION_ADD,    32'h7FFF_FFFF, 32'h0000_0009, ON, OFF, 32'h0, OFF, ON);
        row_item(ACTION_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000, ON, ON, 32'h9, OFF, OFF);
        row_item(ACTION_ADD,    32'h0000_0002, 32'h0000_0002, OFF, OFF, 32'h0, OFF, OFF);
        // A limit above the depth acts as the depth.
        row_limit(7'd127);
        row_item(ACTION_ADD,    32'hFFFF_FFFF, 32'h0000_0003, ON, OFF, 32'h0, ON, OFF);
        row_item(ACTION_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, ON, ON, 32'hAAAA_AAAA, OFF, OFF);
        row_item(ACTION_LOOKUP, 32'h0000_0000, 32'h0000_0000, ON, ON, 32'h5555_5555, OFF, OFF);
        row_item(ACTION_LOOKUP, 32'h0000_0002, 32'h0000_0000, OFF, OFF, 32'h0, OFF, OFF);

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].is_limit_write) begin
                write_limit(directed_rows[r].limit_value);
            end else begin
                present_item(directed_rows[r].item, directed_rows[r].typed,
                             directed_rows[r].want);
            end
        end

        // One phase runs with start held high whenever an item is ready.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            run_random_phase(phase_limits[p], (p == 5) ? 0 : 38);
        end

        settle();
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

### filelist.f
sv/fes_pkg.sv
sv/fes_ctrl.sv
sv/fes_datapath.sv
sv/fifo_evicting_keyed_store.sv
bench/fifo_evicting_keyed_store_test.sv
